>>> hdl/avup_pkg.sv
package avup_pkg;

  localparam int ACC_W      = 56;
  localparam int MAX_SHIFT  = 53;
  localparam int DIGIT_BITS = 7;
  localparam int ENTRY_W    = 15;
  localparam int BYTE_W     = 8;

  typedef enum logic [2:0] {
    K_COUNT,
    K_CLIENT,
    K_CLOCK,
    K_SLEN,
    K_SBYTE,
    K_END
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_LONG,
    ST_SAFE,
    ST_TRUNC,
    ST_COUNT,
    ST_STRING,
    ST_TRAIL
  } status_e;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_CLIENT,
    PH_CLOCK,
    PH_SLEN,
    PH_SBYTES,
    PH_DONE,
    PH_CLOSED
  } phase_e;

  // What one accepted byte leaves for the back end: an optional field and an optional end.
  typedef struct packed {
    logic    has_field;
    kind_e   field_kind;
    logic    has_end;
    status_e end_status;
  } ctl_t;

endpackage

>>> hdl/avup_ifs.sv
interface avup_msg_if #(parameter int LENGTH_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [7:0]             data_byte;
  logic                   first_byte;
  logic                   final_byte;
  logic [LENGTH_BITS-1:0] message_length;

  modport source(output valid, data_byte, first_byte, final_byte, message_length,
                 input ready);
  modport sink(input valid, data_byte, first_byte, final_byte, message_length,
               output ready);
endinterface

interface avup_res_if #(parameter int VALUE_W = 53);
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [VALUE_W-1:0] value;
  logic [14:0]        entry_number;
  logic [2:0]         status;
  logic               run_last;

  modport source(output valid, kind, value, entry_number, status, run_last,
                 input ready);
  modport sink(input valid, kind, value, entry_number, status, run_last,
               output ready);
endinterface

>>> hdl/awareness_update_varint_parser.sv
// A byte's first result is registered in the queue, then in the output register.
// Throughput: one byte per cycle while the queue has room; the output register gives one
// result per cycle if res is ready; the queue absorbs a closing field byte's two results.
// Bytes that complete nothing (varint continuation, ignored bytes) produce no result.
// Synchronous active-high reset clears the parser to expect a count and empties the queue.
module awareness_update_varint_parser
  import avup_pkg::*;
#(
  parameter int LENGTH_BITS = 16,
  parameter int VALUE_BITS  = 53,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  avup_msg_if.sink   msg,
  avup_res_if.source res
);

  localparam int VALUE_W = (VALUE_BITS > BYTE_W) ? VALUE_BITS : BYTE_W;
  localparam int Q_W     = $bits(ctl_t) + VALUE_W + 2 * ENTRY_W;

  logic               push, pop, full, head_valid;
  ctl_t               f_ctl, h_ctl;
  logic [VALUE_W-1:0] f_value, h_value;
  logic [ENTRY_W-1:0] f_field_entry, f_end_entry, h_field_entry, h_end_entry;
  logic [Q_W-1:0]     head;

  avup_front #(
    .LENGTH_BITS(LENGTH_BITS),
    .VALUE_BITS (VALUE_BITS),
    .VALUE_W    (VALUE_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .full       (full),
    .push       (push),
    .ctl        (f_ctl),
    .value      (f_value),
    .field_entry(f_field_entry),
    .end_entry  (f_end_entry)
  );

  avup_queue #(
    .W    (Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     ({f_ctl, f_value, f_field_entry, f_end_entry}),
    .pop       (pop),
    .full      (full),
    .head_valid(head_valid),
    .head      (head)
  );

  assign {h_ctl, h_value, h_field_entry, h_end_entry} = head;

  avup_back #(
    .VALUE_W(VALUE_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .ctl        (h_ctl),
    .value      (h_value),
    .field_entry(h_field_entry),
    .end_entry  (h_end_entry),
    .pop        (pop),
    .res        (res)
  );

endmodule

>>> hdl/avup_front.sv
module avup_front
  import avup_pkg::*;
#(
  parameter int LENGTH_BITS = 16,
  parameter int VALUE_BITS  = 53,
  parameter int VALUE_W     = 53
) (
  input  logic                clk,
  input  logic                rst,
  avup_msg_if.sink            msg,
  input  logic                full,
  output logic                push,
  output ctl_t                ctl,
  output logic [VALUE_W-1:0]  value,
  output logic [ENTRY_W-1:0]  field_entry,
  output logic [ENTRY_W-1:0]  end_entry
);

  localparam int LB = LENGTH_BITS;

  phase_e            phase, phase_next;
  logic              failed, failed_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [5:0]        shift, shift_next;
  logic [LB-1:0]     entries_left, entries_left_next;
  logic [ENTRY_W-1:0] entry_index, entry_index_next;
  logic [LB-1:0]     str_left, str_left_next;
  logic [LB-1:0]     remaining, remaining_next;
  logic [LB-1:0]     total, total_next;

  logic              accept, first, ignore, last;
  phase_e            eff_phase;
  logic [ACC_W-1:0]  eff_acc, acc_or;
  logic [5:0]        eff_shift;
  logic [LB-1:0]     eff_entries, eff_str, eff_rem, eff_total, rem_dec, low;
  logic [ENTRY_W-1:0] eff_index;
  logic              hi, over_safe, count_big, str_big;
  logic [LB+1:0]     triple;

  // results of the step
  status_e           err, status_fin;
  logic              fld, adv, close;
  kind_e             fkind;
  phase_e            ph_step;
  logic [ACC_W-1:0]  acc_step;
  logic [5:0]        shift_step;
  logic [LB-1:0]     ent_step, str_step;
  logic [ENTRY_W-1:0] idx_step;

  assign msg.ready = !full;
  assign accept    = msg.valid && msg.ready;
  assign first     = msg.first_byte;
  assign ignore    = !first && (failed || phase == PH_CLOSED);

  // A first byte restarts the parser before the byte itself is taken.
  assign eff_phase   = first ? PH_COUNT : phase;
  assign eff_acc     = first ? '0 : acc;
  assign eff_shift   = first ? '0 : shift;
  assign eff_entries = first ? '0 : entries_left;
  assign eff_index   = first ? '0 : entry_index;
  assign eff_str     = first ? '0 : str_left;
  assign eff_rem     = first ? msg.message_length : remaining;
  assign eff_total   = first ? msg.message_length : total;

  assign rem_dec   = eff_rem - LB'(1);
  assign last      = msg.final_byte || rem_dec == '0;
  assign acc_or    = eff_acc | (ACC_W'(msg.data_byte[DIGIT_BITS-1:0]) << eff_shift);
  assign hi        = |acc_or[ACC_W-1:LB];
  assign low       = acc_or[LB-1:0];
  assign over_safe = |acc_or[ACC_W-1:VALUE_BITS];
  // count > total/3 exactly when 3*count > total
  assign triple    = {2'b00, low} + {1'b0, low, 1'b0};
  assign count_big = hi || triple > {2'b00, eff_total};
  assign str_big   = hi || low > rem_dec;

  always_comb begin
    err        = ST_OK;
    fld        = 1'b0;
    fkind      = K_COUNT;
    adv        = 1'b0;
    ph_step    = eff_phase;
    acc_step   = eff_acc;
    shift_step = eff_shift;
    ent_step   = eff_entries;
    str_step   = eff_str;
    idx_step   = eff_index;
    if (eff_rem == '0) begin
      err = ST_TRUNC;
    end else begin
      case (eff_phase)
        PH_DONE: begin
          err = ST_TRAIL;
        end
        PH_SBYTES: begin
          fld      = 1'b1;
          fkind    = K_SBYTE;
          str_step = eff_str - LB'(1);
          adv      = str_step == '0;
        end
        default: begin
          if (eff_shift > 6'(MAX_SHIFT)) begin
            err = ST_LONG;
          end else if (msg.data_byte[BYTE_W-1]) begin
            acc_step   = acc_or;
            shift_step = eff_shift + 6'(DIGIT_BITS);
          end else begin
            acc_step   = '0;
            shift_step = '0;
            if (over_safe) begin
              err = ST_SAFE;
            end else begin
              case (eff_phase)
                PH_COUNT: begin
                  if (count_big) begin
                    err = ST_COUNT;
                  end else begin
                    fld      = 1'b1;
                    fkind    = K_COUNT;
                    ent_step = low;
                    ph_step  = (low == '0) ? PH_DONE : PH_CLIENT;
                  end
                end
                PH_CLIENT: begin
                  fld     = 1'b1;
                  fkind   = K_CLIENT;
                  ph_step = PH_CLOCK;
                end
                PH_CLOCK: begin
                  fld     = 1'b1;
                  fkind   = K_CLOCK;
                  ph_step = PH_SLEN;
                end
                default: begin
                  if (str_big) begin
                    err = ST_STRING;
                  end else begin
                    fld   = 1'b1;
                    fkind = K_SLEN;
                    if (low == '0) begin
                      adv = 1'b1;
                    end else begin
                      str_step = low;
                      ph_step  = PH_SBYTES;
                    end
                  end
                end
              endcase
            end
          end
        end
      endcase
    end
    if (adv) begin
      idx_step = eff_index + ENTRY_W'(1);
      ent_step = eff_entries - LB'(1);
      ph_step  = (ent_step == '0) ? PH_DONE : PH_CLIENT;
    end
    close      = 1'b0;
    status_fin = err;
    if (err == ST_OK && last) begin
      if (ph_step == PH_DONE) begin
        close = 1'b1;
      end else begin
        status_fin = ST_TRUNC;
      end
    end
  end

  // next state
  always_comb begin
    phase_next        = phase;
    failed_next       = failed;
    acc_next          = acc;
    shift_next        = shift;
    entries_left_next = entries_left;
    entry_index_next  = entry_index;
    str_left_next     = str_left;
    remaining_next    = remaining;
    total_next        = total;
    if (accept && !ignore) begin
      phase_next        = close ? PH_CLOSED : ph_step;
      failed_next       = status_fin != ST_OK;
      acc_next          = acc_step;
      shift_next        = shift_step;
      entries_left_next = ent_step;
      entry_index_next  = idx_step;
      str_left_next     = str_step;
      remaining_next    = (eff_rem == '0) ? eff_rem : rem_dec;
      total_next        = eff_total;
    end
  end

  // outputs towards the queue
  always_comb begin
    ctl.has_field  = fld && status_fin == ST_OK;
    ctl.field_kind = fkind;
    ctl.has_end    = close || status_fin != ST_OK;
    ctl.end_status = status_fin;
    value          = (fkind == K_SBYTE) ? VALUE_W'(msg.data_byte) : VALUE_W'(acc_or);
    field_entry    = (fkind == K_COUNT) ? '0 : eff_index;
    end_entry      = idx_step;
    push           = accept && !ignore && (ctl.has_field || ctl.has_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_COUNT;
      failed       <= 1'b0;
      acc          <= '0;
      shift        <= '0;
      entries_left <= '0;
      entry_index  <= '0;
      str_left     <= '0;
      remaining    <= '0;
      total        <= '0;
    end else begin
      phase        <= phase_next;
      failed       <= failed_next;
      acc          <= acc_next;
      shift        <= shift_next;
      entries_left <= entries_left_next;
      entry_index  <= entry_index_next;
      str_left     <= str_left_next;
      remaining    <= remaining_next;
      total        <= total_next;
    end
  end

`ifndef SYNTHESIS
  a_count_phase_index: assert property (@(posedge clk) disable iff (rst)
    phase == PH_COUNT |-> entry_index == '0)
    else $error("entry index moved before the count was read");

  a_failed_silent: assert property (@(posedge clk) disable iff (rst)
    accept && !first && failed |-> !push)
    else $error("item queued after a failed message");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    shift <= 6'(ACC_W))
    else $error("varint shift beyond accumulator");
`endif

endmodule

>>> hdl/avup_queue.sv
module avup_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         full,
  output logic         head_valid,
  output logic [W-1:0] head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full queue");
`endif

endmodule

>>> hdl/avup_back.sv
module avup_back
  import avup_pkg::*;
#(
  parameter int VALUE_W = 53
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  ctl_t               ctl,
  input  logic [VALUE_W-1:0] value,
  input  logic [ENTRY_W-1:0] field_entry,
  input  logic [ENTRY_W-1:0] end_entry,
  output logic               pop,
  avup_res_if.source         res
);

  logic               out_valid, out_valid_next;
  kind_e              out_kind, out_kind_next;
  logic [VALUE_W-1:0] out_value, out_value_next;
  logic [ENTRY_W-1:0] out_entry, out_entry_next;
  status_e            out_status, out_status_next;
  logic               out_last, out_last_next;
  logic               pend_end, pend_end_next;
  status_e            pend_status, pend_status_next;
  logic [ENTRY_W-1:0] pend_entry, pend_entry_next;
  logic               load_ok;

  assign load_ok = !out_valid || res.ready;

  always_comb begin
    pop              = 1'b0;
    out_valid_next   = out_valid;
    out_kind_next    = out_kind;
    out_value_next   = out_value;
    out_entry_next   = out_entry;
    out_status_next  = out_status;
    out_last_next    = out_last;
    pend_end_next    = pend_end;
    pend_status_next = pend_status;
    pend_entry_next  = pend_entry;
    if (load_ok) begin
      if (pend_end) begin
        // second result of the same byte
        out_valid_next  = 1'b1;
        out_kind_next   = K_END;
        out_value_next  = '0;
        out_entry_next  = pend_entry;
        out_status_next = pend_status;
        out_last_next   = 1'b1;
        pend_end_next   = 1'b0;
      end else if (head_valid) begin
        pop            = 1'b1;
        out_valid_next = 1'b1;
        if (ctl.has_field) begin
          out_kind_next    = ctl.field_kind;
          out_value_next   = value;
          out_entry_next   = field_entry;
          out_status_next  = ST_OK;
          out_last_next    = !ctl.has_end;
          pend_end_next    = ctl.has_end;
          pend_status_next = ctl.end_status;
          pend_entry_next  = end_entry;
        end else begin
          out_kind_next   = K_END;
          out_value_next  = '0;
          out_entry_next  = end_entry;
          out_status_next = ctl.end_status;
          out_last_next   = 1'b1;
        end
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_end  <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      pend_end  <= pend_end_next;
    end
  end

  always_ff @(posedge clk) begin
    out_kind    <= out_kind_next;
    out_value   <= out_value_next;
    out_entry   <= out_entry_next;
    out_status  <= out_status_next;
    out_last    <= out_last_next;
    pend_status <= pend_status_next;
    pend_entry  <= pend_entry_next;
  end

  assign res.valid        = out_valid;
  assign res.kind         = out_kind;
  assign res.value        = out_value;
  assign res.entry_number = out_entry;
  assign res.status       = out_status;
  assign res.run_last     = out_last;

`ifndef SYNTHESIS
  a_pend_behind_field: assert property (@(posedge clk) disable iff (rst)
    pend_end |-> out_valid && !out_last)
    else $error("pending end without its field in the output register");
`endif

endmodule
